[design/mld_pkg.sv]
// Shared types and constants for the load-delay integer core.
package mld_pkg;

  localparam logic [31:0] RESET_PC      = 32'hBFC0_0000;
  localparam logic [31:0] SEG_MASK      = 32'hE000_0000;
  localparam logic [31:0] VEC_BOOT      = 32'hBFC0_0180;
  localparam logic [31:0] VEC_NORMAL    = 32'h8000_0080;
  localparam logic [31:0] RESET_STATUS  = 32'h0040_0000;
  localparam int          BEV_BIT       = 22;

  typedef enum logic [2:0] {
    ST_RETIRED  = 3'd0,
    ST_READ_REQ = 3'd1,
    ST_EXC      = 3'd2,
    ST_UNSUP    = 3'd3,
    ST_BUS_ERR  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    EXC_NONE = 4'd0,
    EXC_ADEL = 4'd4,
    EXC_OVF  = 4'd12
  } exc_code_t;

  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;

  localparam logic [2:0] LK_LB  = 3'd0;
  localparam logic [2:0] LK_LH  = 3'd1;
  localparam logic [2:0] LK_LWL = 3'd2;
  localparam logic [2:0] LK_LW  = 3'd3;
  localparam logic [2:0] LK_LBU = 3'd4;
  localparam logic [2:0] LK_LHU = 3'd5;
  localparam logic [2:0] LK_LWR = 3'd6;

  // One queued input word
  typedef struct packed {
    logic        is_data;
    logic [31:0] word;
  } item_t;

  // Queue head handed to the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [3:0]  exception_code;
    logic [31:0] load_write_value;
    logic [4:0]  load_write_reg;
    logic        load_write_valid;
    logic [31:0] alu_write_value;
    logic [4:0]  alu_write_reg;
    logic        alu_write_valid;
    logic [31:0] read_address;
    logic [31:0] next_pc;
    logic [2:0]  status;
  } result_t;

endpackage

[design/mld_front.sv]
// Input stage: accepts words into a two-entry queue ahead of the execute stage.
module mld_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mld_pkg::item_t  in_item,
  output mld_pkg::head_t  head,
  input  logic            pop
);

  mld_pkg::item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, do_pop;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count overflow");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 && !do_pop) |=> count_r == 2'd2) else $error("queue lost entry");
  a_pop_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1 && do_pop && !push) |=> count_r == 2'd0) else $error("pop miscount");
`endif

endmodule

[design/mld_back.sv]
// Execute stage: register file, load delay slot, exceptions and result register.
module mld_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mld_pkg::head_t    head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mld_pkg::result_t  out_res
);

  logic [31:0] gpr_r [32];
  logic [31:0] pc_r, pc_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic        pend_merge_r, pend_merge_nxt;
  logic [4:0]  pend_reg_r, pend_reg_nxt;
  logic [31:0] pend_value_r, pend_value_nxt;
  logic        await_r, await_nxt;
  logic [2:0]  await_kind_r, await_kind_nxt;
  logic [4:0]  await_reg_r, await_reg_nxt;
  logic [1:0]  await_byte_r, await_byte_nxt;
  logic [31:0] await_base_r, await_base_nxt;
  logic [31:0] status_word_r, status_word_nxt;
  logic [31:0] cause_r, cause_nxt;
  logic [31:0] epc_r, epc_nxt;
  logic        out_valid_r;
  mld_pkg::result_t res_r, res;

  logic        wa_en, wl_en;
  logic [4:0]  wa_reg, wl_reg;
  logic [31:0] wa_val, wl_val;

  logic [31:0] w;
  logic [5:0]  prim, funct;
  logic [4:0]  rs, rt, rd;
  logic [31:0] s_val, t_val, sum, dif, addr, phys, lval, off;
  logic [4:0]  sh;
  logic [15:0] half;
  logic [7:0]  byte_v;
  logic        ovf_add, ovf_sub, misal;
  logic [2:0]  kind;

  assign pop       = head.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // decode fields and operands
  always_comb begin
    w      = head.item.word;
    prim   = w[31:26];
    funct  = w[5:0];
    rs     = w[25:21];
    rt     = w[20:16];
    rd     = w[15:11];
    kind   = w[28:26];
    s_val  = gpr_r[rs];
    t_val  = gpr_r[rt];
    sum    = s_val + t_val;
    dif    = s_val - t_val;
    ovf_add = (s_val[31] ~^ t_val[31]) && (sum[31] != s_val[31]);
    ovf_sub = (s_val[31] ^ t_val[31]) && (dif[31] != s_val[31]);
    off    = {{16{w[15]}}, w[15:0]};
    addr   = s_val + off;
    misal  = ((kind == mld_pkg::LK_LH || kind == mld_pkg::LK_LHU) && addr[0])
          || (kind == mld_pkg::LK_LW && (addr[1:0] != 2'b00));
    phys   = (addr[31:30] == 2'b11) ? addr : (addr & ~mld_pkg::SEG_MASK);
    sh     = {await_byte_r, 3'b000};
    byte_v = 8'(w >> sh);
    half   = await_byte_r[1] ? w[31:16] : w[15:0];
  end

  // shape returned memory word
  always_comb begin
    unique case (await_kind_r)
      mld_pkg::LK_LB:  lval = {{24{byte_v[7]}}, byte_v};
      mld_pkg::LK_LBU: lval = {24'd0, byte_v};
      mld_pkg::LK_LH:  lval = {{16{half[15]}}, half};
      mld_pkg::LK_LHU: lval = {16'd0, half};
      mld_pkg::LK_LWL: lval = (await_byte_r == 2'd3) ? w :
        ((await_base_r & (32'h00FF_FFFF >> sh)) | (w << (5'd24 - sh)));
      mld_pkg::LK_LWR: lval = (await_byte_r == 2'd0) ? w :
        ((await_base_r & ~(32'hFFFF_FFFF >> sh)) | (w >> sh));
      default:         lval = w;
    endcase
  end

  // execute one word
  always_comb begin
    pc_nxt          = pc_r;
    pend_valid_nxt  = pend_valid_r;
    pend_merge_nxt  = pend_merge_r;
    pend_reg_nxt    = pend_reg_r;
    pend_value_nxt  = pend_value_r;
    await_nxt       = await_r;
    await_kind_nxt  = await_kind_r;
    await_reg_nxt   = await_reg_r;
    await_byte_nxt  = await_byte_r;
    await_base_nxt  = await_base_r;
    status_word_nxt = status_word_r;
    cause_nxt       = cause_r;
    epc_nxt         = epc_r;
    wa_en  = 1'b0; wa_reg = rd;         wa_val = 32'd0;
    wl_en  = 1'b0; wl_reg = pend_reg_r; wl_val = pend_value_r;
    res = '0;
    res.status = mld_pkg::ST_UNSUP;

    if (head.item.is_data) begin
      if (await_r) begin
        wl_en          = pend_valid_r;
        pend_valid_nxt = 1'b1;
        pend_merge_nxt = (await_kind_r == mld_pkg::LK_LWL) ||
                         (await_kind_r == mld_pkg::LK_LWR);
        pend_reg_nxt   = await_reg_r;
        pend_value_nxt = lval;
        await_nxt      = 1'b0;
        pc_nxt         = pc_r + 32'd4;
        res.status     = mld_pkg::ST_RETIRED;
      end
    end else if (!await_r) begin
      if (prim == 6'd0 && (funct == mld_pkg::FN_ADD || funct == mld_pkg::FN_ADDU ||
                           funct == mld_pkg::FN_SUB || funct == mld_pkg::FN_SUBU)) begin
        if ((funct == mld_pkg::FN_ADD && ovf_add) || (funct == mld_pkg::FN_SUB && ovf_sub)) begin
          epc_nxt = pc_r;
          status_word_nxt = {status_word_r[31:6], status_word_r[3:0], 2'b00};
          cause_nxt = {26'd0, mld_pkg::EXC_OVF, 2'b00};
          pc_nxt = status_word_r[mld_pkg::BEV_BIT] ? mld_pkg::VEC_BOOT : mld_pkg::VEC_NORMAL;
          res.status = mld_pkg::ST_EXC;
          res.exception_code = mld_pkg::EXC_OVF;
        end else begin
          wa_en  = 1'b1;
          wa_val = funct[1] ? dif : sum;
          wl_en  = pend_valid_r && (pend_reg_r != rd);
          pend_valid_nxt = 1'b0;
          pc_nxt = pc_r + 32'd4;
          res.status = mld_pkg::ST_RETIRED;
        end
      end else if (prim[5:3] == 3'b100 && prim[2:0] != 3'b111) begin
        if (misal) begin
          epc_nxt = pc_r;
          status_word_nxt = {status_word_r[31:6], status_word_r[3:0], 2'b00};
          cause_nxt = {26'd0, mld_pkg::EXC_ADEL, 2'b00};
          pc_nxt = status_word_r[mld_pkg::BEV_BIT] ? mld_pkg::VEC_BOOT : mld_pkg::VEC_NORMAL;
          res.status = mld_pkg::ST_EXC;
          res.exception_code = mld_pkg::EXC_ADEL;
        end else if (addr[31:29] != 3'b000 && addr[31] == 1'b0) begin
          res.status = mld_pkg::ST_BUS_ERR;
        end else begin
          await_nxt      = 1'b1;
          await_kind_nxt = kind;
          await_reg_nxt  = rt;
          await_byte_nxt = addr[1:0];
          await_base_nxt = (pend_valid_r && pend_merge_r && pend_reg_r == rt)
                           ? pend_value_r : t_val;
          res.status       = mld_pkg::ST_READ_REQ;
          res.read_address = {phys[31:2], 2'b00};
        end
      end
    end

    res.next_pc          = pc_nxt;
    res.alu_write_valid  = wa_en;
    res.alu_write_reg    = wa_en ? wa_reg : 5'd0;
    res.alu_write_value  = (wa_en && wa_reg != 5'd0) ? wa_val : 32'd0;
    res.load_write_valid = wl_en;
    res.load_write_reg   = wl_en ? wl_reg : 5'd0;
    res.load_write_value = (wl_en && wl_reg != 5'd0) ? wl_val : 32'd0;
  end

  // hold architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= mld_pkg::RESET_PC;
      pend_valid_r  <= 1'b0;
      pend_merge_r  <= 1'b0;
      pend_reg_r    <= 5'd0;
      pend_value_r  <= 32'd0;
      await_r       <= 1'b0;
      await_kind_r  <= 3'd0;
      await_reg_r   <= 5'd0;
      await_byte_r  <= 2'd0;
      await_base_r  <= 32'd0;
      status_word_r <= mld_pkg::RESET_STATUS;
      cause_r       <= 32'd0;
      epc_r         <= 32'd0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < 32; i++) gpr_r[i] <= 32'd0;
    end else begin
      if (pop) begin
        pc_r          <= pc_nxt;
        pend_valid_r  <= pend_valid_nxt;
        pend_merge_r  <= pend_merge_nxt;
        pend_reg_r    <= pend_reg_nxt;
        pend_value_r  <= pend_value_nxt;
        await_r       <= await_nxt;
        await_kind_r  <= await_kind_nxt;
        await_reg_r   <= await_reg_nxt;
        await_byte_r  <= await_byte_nxt;
        await_base_r  <= await_base_nxt;
        status_word_r <= status_word_nxt;
        cause_r       <= cause_nxt;
        epc_r         <= epc_nxt;
        if (wa_en && wa_reg != 5'd0) gpr_r[wa_reg] <= wa_val;
        if (wl_en && wl_reg != 5'd0) gpr_r[wl_reg] <= wl_val;
      end
      if (pop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // capture result word
  always_ff @(posedge clk) begin
    if (pop) res_r <= res;
  end

`ifndef SYNTH
  a_zero_reg: assert property (@(posedge clk) disable iff (!rst_n)
    gpr_r[0] == 32'd0) else $error("register zero written");
  a_req_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == mld_pkg::ST_READ_REQ) |-> res_r.read_address[1:0] == 2'b00)
    else $error("unaligned read request");
  a_exc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.status == mld_pkg::ST_EXC) == (res_r.exception_code != 4'd0)))
    else $error("exception code mismatch");
  a_req_awaits: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && res.status == mld_pkg::ST_READ_REQ) |=> await_r) else $error("request not awaited");
`endif

endmodule

[design/mips_load_delay_core.sv]
// Top level of the load-delay integer core: input queue plus execute stage.
// Usage:
//   in_tuser[0] = 1 marks a memory data word answering the last read request,
//   0 marks an instruction word fetched at the last reported next_pc.
//   in_tdata carries the 32-bit word. Every accepted word yields one result
//   word on out_*, carrying status, next_pc, read request address, register
//   writes and exception code.
// Path: an accepted word is stored in the queue; the queue head feeds the
//   execute stage directly, whose result register loads when the head is
//   popped.
// Throughput: one word per cycle while out_tready is high; the execute stage
//   reads the register file, does one add or subtract and updates state per popped word.
// Reset: rst_n low empties the queue and result register, clears registers
//   and puts the program counter at the reset address RESET_PC.
// Stall: when out_tready is low with a result pending, the result register holds, the
//   execute stage waits and the two-entry queue fills; in_tready falls once it is full.
module mips_load_delay_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] data_word
  input  logic [0:0]   in_tuser,   // [0] is_data flag (1 = memory data word)
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata   // status, next_pc, read_address, alu_write_valid,
                                   // alu_write_reg, alu_write_value, load_write_valid,
                                   // load_write_reg, load_write_value, exception_code, pad
);

  mld_pkg::item_t   in_item;
  mld_pkg::head_t   head;
  mld_pkg::result_t res;
  logic             pop;

  assign in_item.is_data = in_tuser[0];
  assign in_item.word    = in_tdata;

  mld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  mld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {5'd0, res};

endmodule
